FILE: hdl/lrudtc_pkg.sv
// Shared types, codes and sizes for the LRU directory tag cache.
package lrudtc_pkg;

    localparam int DEF_CACHE_DEPTH = 8;
    localparam int TAG_W           = 28;
    localparam int HANDLE_W        = 16;
    localparam int COUNT_W         = 4;
    localparam int QUEUE_DEPTH     = 2;

    // Command kind codes on the input port
    localparam logic [1:0] KIND_DISCARD = 2'd0;
    localparam logic [1:0] KIND_REQUEST = 2'd1;
    localparam logic [1:0] KIND_FLUSH   = 2'd2;

    // Input transaction
    typedef struct packed {
        logic [1:0]          kind;
        logic [TAG_W-1:0]    tag;
        logic [HANDLE_W-1:0] handle;
        logic                deleted;
    } cmd_t;

    // Result transaction
    typedef struct packed {
        logic                found;
        logic [HANDLE_W-1:0] found_handle;
        logic                release_valid;
        logic [HANDLE_W-1:0] release_handle;
        logic [COUNT_W-1:0]  cached_count;
        logic                last;
    } result_t;

    // Classified operation handed from front to back
    typedef enum logic [2:0] {
        OP_INSERT,
        OP_DROP,
        OP_LOOKUP,
        OP_FLUSH,
        OP_NONE
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic [TAG_W-1:0]    tag;
        logic [HANDLE_W-1:0] handle;
    } work_t;

    // Queue status seen by the front end
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // One cached entry
    typedef struct packed {
        logic [TAG_W-1:0]    tag;
        logic [HANDLE_W-1:0] handle;
    } entry_t;

endpackage

FILE: hdl/lrudtc_front.sv
// Front end: takes commands and classifies them into work items.
module lrudtc_front
    import lrudtc_pkg::*;
(
    input  logic          start,
    input  cmd_t          cmd,
    input  queue_status_t q_status,
    output logic          busy,
    output logic          push,
    output work_t         work
);

    // Accept whenever the queue has room
    assign busy = q_status.full;
    assign push = start & ~q_status.full;

    // Decode command kind into an operation
    always_comb
    begin
        work.tag    = cmd.tag;
        work.handle = cmd.handle;
        unique case (cmd.kind)
            KIND_DISCARD: work.op = cmd.deleted ? OP_DROP : OP_INSERT;
            KIND_REQUEST: work.op = OP_LOOKUP;
            KIND_FLUSH:   work.op = OP_FLUSH;
            default:      work.op = OP_NONE;
        endcase
    end

endmodule

FILE: hdl/lrudtc_queue.sv
// Short work queue between front end and back end.
module lrudtc_queue
    import lrudtc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  work_t         push_data,
    input  logic          pop,
    output work_t         pop_data,
    output queue_status_t status
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int LW = $clog2(QUEUE_DEPTH + 1);

    work_t          slot_reg [QUEUE_DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [LW-1:0]  level_reg, level_next;
    logic           do_push, do_pop;

    assign status.full  = (level_reg == LW'(QUEUE_DEPTH));
    assign status.empty = (level_reg == '0);
    assign do_push      = push & ~status.full;
    assign do_pop       = pop & ~status.empty;
    assign pop_data     = slot_reg[rd_ptr_reg];

    // Pointer and level update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    // Queue storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: hdl/lrudtc_back.sv
// Back end: sequencer over the recency-ordered entry memory.
module lrudtc_back
    import lrudtc_pkg::*;
#(
    parameter int CACHE_DEPTH = DEF_CACHE_DEPTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  queue_status_t q_status,
    input  work_t         q_data,
    output logic          pop,
    output logic          result_valid,
    output result_t       result
);

    localparam int IW = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
    localparam int CW = $clog2(CACHE_DEPTH + 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVT_RD,
        ST_EVT_CAP,
        ST_INS_RD,
        ST_INS_WR,
        ST_REQ_RD,
        ST_REQ_CMP,
        ST_DEL_RD,
        ST_DEL_WR,
        ST_FL_RD,
        ST_FL_OUT
    } state_t;

    // Entry memory, position 0 is most recent
    entry_t         mem [CACHE_DEPTH];
    entry_t         rd_data_reg;
    logic [IW-1:0]  rd_addr;
    logic           mem_we;
    logic [IW-1:0]  mem_wa;
    entry_t         mem_wd;

    state_t         state_reg, state_next;
    work_t          work_reg, work_next;
    logic [IW-1:0]  ptr_reg, ptr_next;
    logic [CW-1:0]  total_reg, total_next;
    logic           res_valid_reg, res_valid_next;
    result_t        res_reg, res_next;
    logic [CW-1:0]  ptr_inc;
    logic [CW-1:0]  total_dec;

    assign result_valid = res_valid_reg;
    assign result       = res_reg;
    assign pop          = (state_reg == ST_IDLE) & ~q_status.empty;
    assign ptr_inc      = CW'(ptr_reg) + CW'(1);
    assign total_dec    = total_reg - CW'(1);

    // Low bits of a count for the result port
    function automatic logic [COUNT_W-1:0] count_out(input logic [CW-1:0] n);
        logic [CW+COUNT_W-1:0] ext;
        ext = {{COUNT_W{1'b0}}, n};
        return ext[COUNT_W-1:0];
    endfunction

    // Read address per step
    always_comb
    begin
        unique case (state_reg)
            ST_EVT_RD: rd_addr = IW'(CACHE_DEPTH - 1);
            ST_INS_RD: rd_addr = ptr_reg - 1'b1;
            ST_DEL_RD: rd_addr = ptr_inc[IW-1:0];
            ST_FL_RD:  rd_addr = total_dec[IW-1:0];
            default:   rd_addr = ptr_reg;
        endcase
    end

    // Memory write per step
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = ptr_reg;
        mem_wd = rd_data_reg;
        if (state_reg == ST_INS_RD && ptr_reg == '0)
        begin
            mem_we = 1'b1;
            mem_wd = '{tag: work_reg.tag, handle: work_reg.handle};
        end
        else if (state_reg == ST_INS_WR || state_reg == ST_DEL_WR)
        begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        work_next      = work_reg;
        ptr_next       = ptr_reg;
        total_next     = total_reg;
        res_valid_next = 1'b0;
        res_next       = res_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    work_next = q_data;
                    res_next  = '0;
                    res_next.last = 1'b1;
                    res_next.cached_count = count_out(total_reg);
                    unique case (q_data.op)
                        OP_INSERT:
                        begin
                            if (total_reg == CW'(CACHE_DEPTH))
                            begin
                                state_next = ST_EVT_RD;
                            end
                            else
                            begin
                                ptr_next   = total_reg[IW-1:0];
                                total_next = total_reg + CW'(1);
                                state_next = ST_INS_RD;
                            end
                        end
                        OP_DROP:
                        begin
                            res_next.release_valid  = 1'b1;
                            res_next.release_handle = q_data.handle;
                            res_valid_next = 1'b1;
                        end
                        OP_LOOKUP:
                        begin
                            if (total_reg == '0)
                            begin
                                res_valid_next = 1'b1;
                            end
                            else
                            begin
                                ptr_next   = '0;
                                state_next = ST_REQ_RD;
                            end
                        end
                        OP_FLUSH:
                        begin
                            if (total_reg == '0)
                            begin
                                res_valid_next = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_FL_RD;
                            end
                        end
                        default:
                        begin
                            res_valid_next = 1'b1;
                        end
                    endcase
                end
            end

            // Fetch the least recent entry when full
            ST_EVT_RD:
            begin
                state_next = ST_EVT_CAP;
            end

            ST_EVT_CAP:
            begin
                res_next.release_valid  = 1'b1;
                res_next.release_handle = rd_data_reg.handle;
                ptr_next   = IW'(CACHE_DEPTH - 1);
                state_next = ST_INS_RD;
            end

            // Shift entries toward the old end, then write the new head
            ST_INS_RD:
            begin
                if (ptr_reg == '0)
                begin
                    res_next.cached_count = count_out(total_reg);
                    res_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    state_next = ST_INS_WR;
                end
            end

            ST_INS_WR:
            begin
                ptr_next   = ptr_reg - 1'b1;
                state_next = ST_INS_RD;
            end

            // Scan from most recent
            ST_REQ_RD:
            begin
                state_next = ST_REQ_CMP;
            end

            ST_REQ_CMP:
            begin
                if (rd_data_reg.tag == work_reg.tag)
                begin
                    res_next.found        = 1'b1;
                    res_next.found_handle = rd_data_reg.handle;
                    total_next = total_dec;
                    if (ptr_inc < total_reg)
                    begin
                        state_next = ST_DEL_RD;
                    end
                    else
                    begin
                        res_next.cached_count = count_out(total_dec);
                        res_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
                else if (ptr_inc == total_reg)
                begin
                    res_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    ptr_next   = ptr_inc[IW-1:0];
                    state_next = ST_REQ_RD;
                end
            end

            // Close the gap left by the hit entry
            ST_DEL_RD:
            begin
                state_next = ST_DEL_WR;
            end

            ST_DEL_WR:
            begin
                if (ptr_inc < total_reg)
                begin
                    ptr_next   = ptr_inc[IW-1:0];
                    state_next = ST_DEL_RD;
                end
                else
                begin
                    res_next.cached_count = count_out(total_reg);
                    res_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            // Release entries oldest first
            ST_FL_RD:
            begin
                state_next = ST_FL_OUT;
            end

            ST_FL_OUT:
            begin
                total_next = total_dec;
                res_next.release_valid  = 1'b1;
                res_next.release_handle = rd_data_reg.handle;
                res_next.cached_count   = count_out(total_dec);
                res_next.last           = (total_dec == '0);
                res_valid_next = 1'b1;
                state_next     = (total_dec == '0) ? ST_IDLE : ST_FL_RD;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            work_reg      <= '{op: OP_NONE, tag: '0, handle: '0};
            ptr_reg       <= '0;
            total_reg     <= '0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            work_reg      <= work_next;
            ptr_reg       <= ptr_next;
            total_reg     <= total_next;
            res_valid_reg <= res_valid_next;
            res_reg       <= res_next;
        end
    end

endmodule

FILE: hdl/lru_directory_tag_cache_unit.sv
// Top level of the LRU directory tag cache.
//
// Caches up to CACHE_DEPTH directory handles keyed by tag, most recent first.
// A command is taken when start is high and busy is low; commands wait in a
// two-entry queue while the back end works through the entry memory, which
// has one read and one write port and moves an entry by a read and a write.
// A deleted discard, an unused kind, or a lookup or flush of an empty cache
// give their result straight from the idle state; a discard shifts entries
// toward the old end and writes the new head, after an eviction read of the
// oldest entry when full; a lookup scans from the most recent entry and moves
// later entries up after a hit; a flush gives one result per entry, oldest
// first. Every result is on the result port for exactly one cycle, marked by
// result_valid, and the receiver cannot hold it off; last marks the final
// result of a transaction. The entry memory needs no clearing after reset.
module lru_directory_tag_cache_unit
    import lrudtc_pkg::*;
#(
    parameter int CACHE_DEPTH = DEF_CACHE_DEPTH
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  cmd_t    cmd,
    output logic    result_valid,
    output result_t result
);

    queue_status_t q_status;
    logic          push;
    logic          pop;
    work_t         push_work;
    work_t         pop_work;

    lrudtc_front u_front (
        .start    (start),
        .cmd      (cmd),
        .q_status (q_status),
        .busy     (busy),
        .push     (push),
        .work     (push_work)
    );

    lrudtc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_work),
        .pop       (pop),
        .pop_data  (pop_work),
        .status    (q_status)
    );

    lrudtc_back #(
        .CACHE_DEPTH (CACHE_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_status     (q_status),
        .q_data       (pop_work),
        .pop          (pop),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

FILE: tb/lru_directory_tag_cache_unit_test.sv
// Self-checking testbench for the LRU directory tag cache: directed table, then random traffic.
`timescale 1ns / 100ps

module lru_directory_tag_cache_unit_test;
    import lrudtc_pkg::*;

    localparam int DEPTH = DEF_CACHE_DEPTH;
    localparam int POOL_N = 12;
    localparam int RANDOM_ITEMS = 155;
    localparam int CALM_TAIL = 30;
    localparam int MAX_LINES = 60;

    // Kind code the block does not use; it must answer with an empty result
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam logic [TAG_W-1:0] TAG_MAX = {TAG_W{1'b1}};
    localparam logic [HANDLE_W-1:0] HANDLE_MAX = {HANDLE_W{1'b1}};

    typedef struct {
        cmd_t    c;
        bit      typed;
        result_t want;
    } stim_row_t;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    cmd_t    cmd;
    logic    result_valid;
    result_t result;

    // Shadow copy of the cache, most recent entry at index 0
    logic [TAG_W-1:0]    shadow_tags[DEPTH];
    logic [HANDLE_W-1:0] shadow_handles[DEPTH];
    int                  shadow_total;

    result_t   step_out[DEPTH];
    result_t   owed_replies[$];
    stim_row_t stim_table[$];
    logic [TAG_W-1:0] tag_pool[POOL_N];
    int        fail_count;
    int        lines_printed;

    lru_directory_tag_cache_unit #(.CACHE_DEPTH(DEPTH)) uut
    (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .cmd(cmd),
        .result_valid(result_valid),
        .result(result)
    );

    // 2 ns clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    task automatic log_failure(input string msg);
        fail_count++;
        if (lines_printed < MAX_LINES)
        begin
            lines_printed++;
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            log_failure($sformatf("%s got %h want %h", name, got, want));
    endtask

    function automatic result_t pack_reply(input logic found, input logic [HANDLE_W-1:0] fh,
                                           input logic rv, input logic [HANDLE_W-1:0] rh,
                                           input logic last);
        result_t r;
        r.found          = found;
        r.found_handle   = fh;
        r.release_valid  = rv;
        r.release_handle = rh;
        r.cached_count   = shadow_total[COUNT_W-1:0];
        r.last           = last;
        return r;
    endfunction

    // Update the shadow cache for one transaction; replies go to step_out
    function automatic int apply_cache_command(input cmd_t c);
        int n;
        int i;
        int hit_at;
        logic evict;
        logic [HANDLE_W-1:0] evicted;
        logic [HANDLE_W-1:0] h;
        n = 0;
        case (c.kind)
            KIND_DISCARD:
            begin
                if (c.deleted)
                begin
                    step_out[0] = pack_reply(1'b0, '0, 1'b1, c.handle, 1'b1);
                    n = 1;
                end
                else
                begin
                    evict = 1'b0;
                    evicted = '0;
                    if (shadow_total == DEPTH)
                    begin
                        evict = 1'b1;
                        evicted = shadow_handles[DEPTH-1];
                    end
                    else
                        shadow_total++;
                    for (i = shadow_total - 1; i > 0; i--)
                    begin
                        shadow_tags[i]    = shadow_tags[i-1];
                        shadow_handles[i] = shadow_handles[i-1];
                    end
                    shadow_tags[0]    = c.tag;
                    shadow_handles[0] = c.handle;
                    step_out[0] = pack_reply(1'b0, '0, evict, evicted, 1'b1);
                    n = 1;
                end
            end
            KIND_REQUEST:
            begin
                hit_at = -1;
                for (i = 0; i < shadow_total && hit_at < 0; i++)
                    if (shadow_tags[i] == c.tag)
                        hit_at = i;
                if (hit_at >= 0)
                begin
                    h = shadow_handles[hit_at];
                    for (i = hit_at; i + 1 < shadow_total; i++)
                    begin
                        shadow_tags[i]    = shadow_tags[i+1];
                        shadow_handles[i] = shadow_handles[i+1];
                    end
                    shadow_total--;
                    step_out[0] = pack_reply(1'b1, h, 1'b0, '0, 1'b1);
                end
                else
                    step_out[0] = pack_reply(1'b0, '0, 1'b0, '0, 1'b1);
                n = 1;
            end
            KIND_FLUSH:
            begin
                if (shadow_total == 0)
                begin
                    step_out[0] = pack_reply(1'b0, '0, 1'b0, '0, 1'b1);
                    n = 1;
                end
                // Oldest first, count drops by one per reply
                while (shadow_total > 0)
                begin
                    h = shadow_handles[shadow_total-1];
                    shadow_total--;
                    step_out[n] = pack_reply(1'b0, '0, 1'b1, h, shadow_total == 0);
                    n++;
                end
            end
            default:
            begin
                step_out[0] = pack_reply(1'b0, '0, 1'b0, '0, 1'b1);
                n = 1;
            end
        endcase
        return n;
    endfunction

    // Offer one transaction, wait for it to be taken, then maybe go idle
    task automatic send_cmd(input stim_row_t row, input bit allow_idle);
        int n;
        int i;
        cmd <= row.c;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        n = apply_cache_command(row.c);
        if (row.typed)
            owed_replies.push_back(row.want);
        else
            for (i = 0; i < n; i++)
                owed_replies.push_back(step_out[i]);
        if (allow_idle && $urandom_range(0, 9) < 3)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
    endtask

    function automatic void add_row(input logic [1:0] kind, input logic [TAG_W-1:0] tag,
                                    input logic [HANDLE_W-1:0] handle, input logic deleted,
                                    input bit typed, input result_t want);
        stim_row_t row;
        row.c.kind    = kind;
        row.c.tag     = tag;
        row.c.handle  = handle;
        row.c.deleted = deleted;
        row.typed     = typed;
        row.want      = want;
        stim_table.push_back(row);
    endfunction

    function automatic result_t reply(input logic found, input logic [HANDLE_W-1:0] fh,
                                      input logic rv, input logic [HANDLE_W-1:0] rh,
                                      input logic [COUNT_W-1:0] count);
        result_t r;
        r.found          = found;
        r.found_handle   = fh;
        r.release_valid  = rv;
        r.release_handle = rh;
        r.cached_count   = count;
        r.last           = 1'b1;
        return r;
    endfunction

    // Random transaction: mostly pool tags so that lookups hit
    function automatic stim_row_t random_cmd();
        stim_row_t row;
        logic [31:0] r32;
        int pick;
        r32 = $urandom();
        row.c.handle = r32[HANDLE_W-1:0];
        r32 = $urandom();
        if ($urandom_range(0, 99) < 85)
            row.c.tag = tag_pool[$urandom_range(0, POOL_N-1)];
        else
            row.c.tag = r32[TAG_W-1:0];
        pick = $urandom_range(0, 99);
        if (pick < 50)
        begin
            row.c.kind    = KIND_DISCARD;
            row.c.deleted = ($urandom_range(0, 7) == 0);
        end
        else
        begin
            if (pick < 85)
                row.c.kind = KIND_REQUEST;
            else if (pick < 93)
                row.c.kind = KIND_FLUSH;
            else
                row.c.kind = KIND_UNUSED;
            row.c.deleted = 1'($urandom_range(0, 1));
        end
        row.typed = 1'b0;
        row.want  = '0;
        return row;
    endfunction

    // Result checker: every strobed result against the oldest owed reply
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n === 1'b1 && result_valid === 1'b1)
        begin
            if (owed_replies.size() == 0)
                log_failure($sformatf("unexpected result %h", result));
            else
            begin
                want = owed_replies.pop_front();
                check_field("found", 32'(result.found), 32'(want.found));
                check_field("found_handle", 32'(result.found_handle),
                            32'(want.found_handle));
                check_field("release_valid", 32'(result.release_valid),
                            32'(want.release_valid));
                check_field("release_handle", 32'(result.release_handle),
                            32'(want.release_handle));
                check_field("cached_count", 32'(result.cached_count),
                            32'(want.cached_count));
                check_field("last", 32'(result.last), 32'(want.last));
            end
        end
    end

    // Stimulus
    initial
    begin
        int i;
        logic [31:0] r32;
        fail_count    = 0;
        lines_printed = 0;
        shadow_total  = 0;
        rst_n = 1'b0;
        start = 1'b0;
        cmd   = '0;
        tag_pool[0] = '0;
        tag_pool[1] = TAG_MAX;
        for (i = 2; i < POOL_N; i++)
        begin
            r32 = $urandom();
            tag_pool[i] = r32[TAG_W-1:0];
        end

        // Directed table
        add_row(KIND_FLUSH, '0, '0, 1'b0, 1, reply(0, '0, 0, '0, 0));
        add_row(KIND_REQUEST, '0, '0, 1'b0, 1, reply(0, '0, 0, '0, 0));
        add_row(KIND_UNUSED, TAG_MAX, HANDLE_MAX, 1'b1, 1, reply(0, '0, 0, '0, 0));
        add_row(KIND_DISCARD, TAG_MAX, HANDLE_MAX, 1'b1, 1, reply(0, '0, 1, HANDLE_MAX, 0));
        add_row(KIND_DISCARD, '0, '0, 1'b0, 1, reply(0, '0, 0, '0, 1));
        add_row(KIND_DISCARD, TAG_MAX, HANDLE_MAX, 1'b0, 1, reply(0, '0, 0, '0, 2));
        // duplicate tag: lookups take the newest first
        add_row(KIND_DISCARD, '0, 16'hAAAA, 1'b0, 0, '0);
        add_row(KIND_REQUEST, '0, '0, 1'b0, 0, '0);
        add_row(KIND_REQUEST, '0, '0, 1'b0, 0, '0);
        add_row(KIND_REQUEST, '0, '0, 1'b0, 0, '0);
        // fill up, then overflow evicts the oldest
        for (i = 1; i <= 7; i++)
            add_row(KIND_DISCARD, TAG_W'(i), HANDLE_W'(16'h1000 + i), 1'b0, 0, '0);
        add_row(KIND_DISCARD, 28'h5555555, 16'h5555, 1'b0, 0, '0);
        add_row(KIND_DISCARD, '0, '0, 1'b1, 1, reply(0, '0, 1, '0, 4'd8));
        add_row(KIND_REQUEST, TAG_MAX, '0, 1'b0, 0, '0);
        add_row(KIND_REQUEST, TAG_W'(4), '0, 1'b0, 0, '0);
        add_row(KIND_UNUSED, '0, '0, 1'b0, 0, '0);
        add_row(KIND_FLUSH, TAG_MAX, HANDLE_MAX, 1'b1, 0, '0);
        add_row(KIND_REQUEST, 28'h5555555, '0, 1'b0, 1, reply(0, '0, 0, '0, 0));
        add_row(KIND_DISCARD, 28'hAAAAAAA, 16'h5555, 1'b0, 0, '0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        foreach (stim_table[k])
            send_cmd(stim_table[k], 1'b1);
        for (i = 0; i < RANDOM_ITEMS; i++)
            send_cmd(random_cmd(), i < RANDOM_ITEMS - CALM_TAIL);
        start <= 1'b0;

        // Drain, then watch for stray results
        while (owed_replies.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (fail_count == 0)
            $display("PASS lru_directory_tag_cache_unit");
        else
            $display("FAIL lru_directory_tag_cache_unit");
        $finish;
    end

    // Hang guard
    initial
    begin
        #200000;
        log_failure($sformatf("timeout with %0d results outstanding", owed_replies.size()));
        $display("FAIL lru_directory_tag_cache_unit");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/lrudtc_pkg.sv
hdl/lrudtc_front.sv
hdl/lrudtc_queue.sv
hdl/lrudtc_back.sv
hdl/lru_directory_tag_cache_unit.sv
tb/lru_directory_tag_cache_unit_test.sv
